>>> hw/rtl/npcl_pkg.sv
// Shared types and constants for the nearest palette color quantizer.
package npcl_pkg;

    // Width of a palette index as seen on the ports and in the register
    localparam int C_IDX_W     = 4;
    localparam int C_NUM_CODES = 1 << C_IDX_W;
    localparam int C_DIST_W    = 10;  // 3 * 255 = 765 fits

    // Any value above the largest distance; entry 0 always beats it
    localparam logic [C_DIST_W-1:0] C_START_BEST = '1;

    // Request function codes
    localparam logic C_FUNC_LOOKUP = 1'b0;
    localparam logic C_FUNC_WRITE  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Lookup token that walks down the cell chain
    typedef struct packed {
        logic                valid;
        t_rgb                color;
        logic [C_DIST_W-1:0] best;
    } t_token;

    function automatic logic [7:0] f_abs_diff(input logic [7:0] a, input logic [7:0] b);
        f_abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> hw/rtl/npcl_cell.sv
// One palette cell: holds an entry and updates the passing lookup token.
module npcl_cell
    import npcl_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_wr_en,
    input  logic [C_IDX_W-1:0] i_wr_idx,
    input  t_rgb               i_wr_color,
    input  logic [C_IDX_W-1:0] i_highest_color,
    input  t_token             i_tok,
    input  logic [IDX_W-1:0]   i_tok_idx,
    output t_token             o_tok,
    output logic [IDX_W-1:0]   o_tok_idx
);

    // Cells past the last addressable code are never written or searched
    localparam bit IN_CODE = (CELL_IDX < C_NUM_CODES);
    localparam logic [C_IDX_W-1:0] MY_CODE = C_IDX_W'(CELL_IDX);
    localparam logic [IDX_W-1:0]   MY_IDX  = IDX_W'(CELL_IDX);

    t_rgb                r_entry;
    t_token              r_tok;
    t_token              n_tok;
    logic [IDX_W-1:0]    r_tok_idx;
    logic [IDX_W-1:0]    n_tok_idx;
    logic [C_DIST_W-1:0] cur_dist;
    logic                search_en;

    assign search_en = IN_CODE && (MY_CODE <= i_highest_color);

    assign cur_dist = C_DIST_W'(f_abs_diff(i_tok.color.red,   r_entry.red))
                    + C_DIST_W'(f_abs_diff(i_tok.color.green, r_entry.green))
                    + C_DIST_W'(f_abs_diff(i_tok.color.blue,  r_entry.blue));

    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        // strict less-than keeps the lowest index on a tie
        if (i_tok.valid && search_en && (cur_dist < i_tok.best)) begin
            n_tok.best = cur_dist;
            n_tok_idx  = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_wr_en && IN_CODE && (i_wr_idx == MY_CODE)) begin
                r_entry <= i_wr_color;
            end
            if (i_advance) begin
                r_tok     <= n_tok;
                r_tok_idx <= n_tok_idx;
            end
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

>>> hw/rtl/nearest_palette_color_l1.sv
// Top level of the nearest palette color quantizer (taxicab distance).
// Lookup: the token walks the cell chain one cell per cycle while the chain is not frozen,
//   then lands in the result register; only one lookup is out at a time, and a stalled
//   result freezes the chain. Writes are accepted only when no lookup is out.
// Reset (synchronous, active low): palette cleared to zeros, highest_color set to 15,
//   chain and result register emptied.
module nearest_palette_color_l1
    import npcl_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [C_IDX_W-1:0] i_cfg_wdata,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [C_IDX_W-1:0] i_entry_index,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [C_IDX_W-1:0] o_color_index
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    // Chain taps: tap 0 is the fresh request, tap k the output of cell k-1.
    t_token           tok     [0:PALETTE_ENTRIES];
    logic [IDX_W-1:0] tok_idx [0:PALETTE_ENTRIES];

    logic [C_IDX_W-1:0] r_highest_color;
    logic               r_busy;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;

    logic   accept;
    logic   accept_lookup;
    logic   accept_write;
    logic   advance;
    logic   last_valid;
    t_rgb   req_color;

    assign req_color     = '{red: i_red, green: i_green, blue: i_blue};

    // One lookup in flight at a time. Writes are held off while a lookup
    // walks the chain so it sees the palette as of its own request.
    assign o_in_ready    = !r_busy;
    assign accept        = i_in_valid && o_in_ready;
    assign accept_lookup = accept && (i_func == C_FUNC_LOOKUP);
    assign accept_write  = accept && (i_func == C_FUNC_WRITE);

    assign last_valid    = tok[PALETTE_ENTRIES].valid;

    // Freeze the chain only when a finished token cannot leave because the
    // result register is still held by the consumer.
    assign advance       = !(last_valid && r_out_valid && !i_out_ready);

    assign tok[0]        = '{valid: accept_lookup, color: req_color, best: C_START_BEST};
    assign tok_idx[0]    = '0;

    for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
        npcl_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_advance       (advance),
            .i_wr_en         (accept_write),
            .i_wr_idx        (i_entry_index),
            .i_wr_color      (req_color),
            .i_highest_color (r_highest_color),
            .i_tok           (tok[k]),
            .i_tok_idx       (tok_idx[k]),
            .o_tok           (tok[k+1]),
            .o_tok_idx       (tok_idx[k+1])
        );
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest_color <= C_IDX_W'(15);
        end else if (i_cfg_we) begin
            r_highest_color <= i_cfg_wdata;
        end
    end

    // Busy from lookup request until its token lands in the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept_lookup) begin
            r_busy <= 1'b1;
        end else if (advance && last_valid) begin
            r_busy <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && last_valid) begin
            r_out_valid <= 1'b1;
            r_out_idx   <= tok_idx[PALETTE_ENTRIES];
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_color_index = C_IDX_W'(r_out_idx);

endmodule

>>> hw/rtl/npcl_checker.sv
// Port-level checker for the nearest palette color quantizer, bound to the top level.
module npcl_checker
    import npcl_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_func,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [C_IDX_W-1:0] o_color_index
);

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_color_index))
        else $error("result dropped or changed while stalled");

    // A lookup request blocks further requests while it walks the chain
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_func == C_FUNC_LOOKUP) |=> !o_in_ready)
        else $error("request accepted behind an unfinished lookup");

    // No result appears right after any request
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // A new result only ever follows a busy cycle
    a_result_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without a lookup in flight");

endmodule

bind nearest_palette_color_l1 npcl_checker u_npcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_func        (i_func),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_color_index (o_color_index)
);
